@@ design/pcs_pkg.sv @@
// shared types, register codes and the duty threshold function for the pulse channel
`default_nettype none

package pcs_pkg;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // register select codes
    localparam logic [2:0] REG_SWEEP       = 3'd0;
    localparam logic [2:0] REG_LENGTH_DUTY = 3'd1;
    localparam logic [2:0] REG_ENVELOPE    = 3'd2;
    localparam logic [2:0] REG_PERIOD_LOW  = 3'd3;
    localparam logic [2:0] REG_PERIOD_HIGH = 3'd4;

    // duty modes
    localparam logic [1:0] DUTY_12 = 2'd0;
    localparam logic [1:0] DUTY_25 = 2'd1;
    localparam logic [1:0] DUTY_50 = 2'd2;

    // period counter wraps at this value
    localparam logic [12:0] PERIOD_WRAP = 13'h800;

    typedef struct packed {
        logic       kind;
        logic       frame_step;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } pcs_item_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       channel_on;
    } pcs_result_t;

    typedef struct packed {
        logic [7:0]  sweep_reg;
        logic [7:0]  length_duty_reg;
        logic [7:0]  envelope_reg;
        logic [7:0]  period_low_reg;
        logic [7:0]  period_high_reg;
        logic        running;
        logic        wave_high;
        logic [1:0]  duty_mode;
        logic [10:0] period_value;
        logic [11:0] period_count;
        logic [1:0]  period_prescale;
        logic [2:0]  sweep_shift;
        logic        sweep_down;
        logic [2:0]  sweep_pace;
        logic [2:0]  sweep_pace_count;
        logic [1:0]  sweep_prescale;
        logic [6:0]  length_count;
        logic        length_prescale;
        logic        length_on;
        logic [3:0]  volume;
        logic        env_up;
        logic [2:0]  env_pace;
        logic [2:0]  env_pace_count;
        logic [2:0]  env_prescale;
    } pcs_state_t;

    // duty threshold: period plus 1/8, 1/4, 1/2 or 3/4 of the remaining span
    function automatic logic [11:0] duty_threshold(input logic [10:0] period,
                                                   input logic [1:0]  mode);
        logic [11:0] total;
        logic [13:0] triple;
        logic [11:0] part;
        total  = 12'h800 - {1'b0, period};
        triple = {2'b00, total} + {1'b0, total, 1'b0};
        case (mode)
            DUTY_12: part = {3'b000, total[11:3]};
            DUTY_25: part = {2'b00, total[11:2]};
            DUTY_50: part = {1'b0, total[11:1]};
            default: part = triple[13:2];
        endcase
        return {1'b0, period} + part;
    endfunction

endpackage

`default_nettype wire

@@ design/pulse_channel_with_sweep_top.sv @@
// Square-wave channel with period sweep: one item per cycle unless stalled; a tick moves from
// transfer in to result out via the input register, then channel update and result register.
// Register writes give no result and take effect once moved from input register to state.
// A stalled result holds the pipe only when the next item is a tick; writes still pass.
// Reset (rst_n low, asynchronous) clears the valid flags and all channel state, so the
// channel comes up stopped.
`default_nettype none

module pulse_channel_with_sweep_top
    import pcs_pkg::*;
#(
    parameter int LENGTH_LIMIT = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire pcs_item_t   item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output pcs_result_t      result
);

    logic        item_valid_reg;
    pcs_item_t   item_reg;
    logic        result_valid_reg;
    pcs_result_t result_reg;
    pcs_result_t chan_result;
    logic        fire;
    logic        accept;

    // the held item proceeds when it is a write or the result slot frees up
    assign fire = item_valid_reg &&
                  (item_reg.kind == KIND_WRITE || !result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !fire;
    assign accept     = item_valid && !item_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    // channel state and update
    pcs_chan #(
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_chan (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (chan_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire && item_reg.kind == KIND_TICK)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item_reg.kind == KIND_TICK)
        begin
            result_reg <= chan_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // stall only while an item is held
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_valid_reg)
        else $error("stall raised with empty input register");

    // a tick never overwrites a result still waiting to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_reg.kind == KIND_TICK) |-> !(result_valid_reg && result_stall))
        else $error("tick result overwrote a pending transfer");

    // a stopped channel is silent
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.channel_on || result_reg.sample == 4'd0))
        else $error("nonzero sample from stopped channel");
`endif

endmodule

`default_nettype wire

@@ design/pcs_sweep_calc.sv @@
// period sweep adder: period plus or minus period shifted right
`default_nettype none

module pcs_sweep_calc
    import pcs_pkg::*;
(
    input  wire logic [10:0] period,
    input  wire logic [2:0]  shift,
    input  wire logic        down,
    output logic      [10:0] swept_period,
    output logic             overflow
);

    logic [10:0] delta;
    logic [11:0] sum;

    // barrel shift, then add or subtract
    assign delta = period >> shift;
    assign sum   = down ? ({1'b0, period} - {1'b0, delta})
                        : ({1'b0, period} + {1'b0, delta});

    // a result of 0x800 or more stops the channel
    assign swept_period = sum[10:0];
    assign overflow     = sum[11];

endmodule

`default_nettype wire

@@ design/pcs_chan.sv @@
// channel state: register writes, trigger, duty, sweep, length and envelope updates
`default_nettype none

module pcs_chan
    import pcs_pkg::*;
#(
    parameter int LENGTH_LIMIT = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire pcs_item_t   item,
    output pcs_result_t      result
);

    localparam logic [7:0] LEN_LIMIT = 8'(LENGTH_LIMIT);

    pcs_state_t  state_reg;
    pcs_state_t  state_next;

    logic [10:0] tick_period;
    logic        tick_ovf;
    logic [11:0] trig_sum;
    logic        trig_ovf;
    logic [10:0] trig_period_in;
    logic [11:0] threshold;
    logic [12:0] count_inc;
    logic [3:0]  sweep_t;
    logic [7:0]  length_t;
    logic [3:0]  env_t;

    // sweep step on a running tick
    pcs_sweep_calc u_tick_sweep (
        .period       (state_reg.period_value),
        .shift        (state_reg.sweep_shift),
        .down         (state_reg.sweep_down),
        .swept_period (tick_period),
        .overflow     (tick_ovf)
    );

    // overflow check at trigger, from the freshly written registers
    assign trig_period_in = {item.write_data[2:0], state_reg.period_low_reg};
    assign trig_sum       = {1'b0, trig_period_in}
                          + {1'b0, trig_period_in >> state_reg.sweep_reg[2:0]};
    assign trig_ovf       = !state_reg.sweep_reg[3] && trig_sum[11];

    assign threshold = duty_threshold(state_reg.period_value, state_reg.duty_mode);
    assign count_inc = {1'b0, state_reg.period_count} + 13'd1;
    assign sweep_t   = {1'b0, state_reg.sweep_pace_count} + 4'd1;
    assign length_t  = {1'b0, state_reg.length_count} + 8'd1;
    assign env_t     = {1'b0, state_reg.env_pace_count} + 4'd1;

    // result reflects the state at the start of the tick
    assign result.channel_on = state_reg.running;
    assign result.sample     = (state_reg.running && state_reg.wave_high) ?
                               state_reg.volume : 4'd0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (item.kind == KIND_WRITE)
        begin
            case (item.reg_select)
                REG_SWEEP:
                begin
                    state_next.sweep_reg = item.write_data;
                end
                REG_LENGTH_DUTY:
                begin
                    state_next.length_duty_reg = item.write_data;
                    state_next.duty_mode       = item.write_data[7:6];
                    state_next.length_count    = {1'b0, item.write_data[5:0]};
                end
                REG_ENVELOPE:
                begin
                    state_next.envelope_reg = item.write_data;
                    if (item.write_data[7:4] == 4'd0 && !item.write_data[3])
                    begin
                        state_next.running = 1'b0;
                    end
                end
                REG_PERIOD_LOW:
                begin
                    state_next.period_low_reg = item.write_data;
                end
                REG_PERIOD_HIGH:
                begin
                    state_next.period_high_reg = item.write_data;
                    state_next.length_on       = item.write_data[6];
                    // trigger
                    if (item.write_data[7])
                    begin
                        state_next.running          = 1'b1;
                        state_next.sweep_pace       = state_reg.sweep_reg[6:4];
                        state_next.sweep_down       = state_reg.sweep_reg[3];
                        state_next.sweep_shift      = state_reg.sweep_reg[2:0];
                        state_next.period_value     = trig_period_in;
                        state_next.volume           = state_reg.envelope_reg[7:4];
                        state_next.env_up           = state_reg.envelope_reg[3];
                        state_next.env_pace         = state_reg.envelope_reg[2:0];
                        if (state_reg.length_count == 7'd0)
                        begin
                            state_next.length_count    = {1'b0, state_reg.length_duty_reg[5:0]};
                            state_next.length_prescale = 1'b0;
                        end
                        state_next.period_count     = 12'd0;
                        state_next.period_prescale  = 2'd0;
                        state_next.sweep_pace_count = 3'd0;
                        state_next.sweep_prescale   = 2'd0;
                        state_next.env_pace_count   = 3'd0;
                        state_next.env_prescale     = 3'd0;
                        state_next.wave_high        = 1'b0;
                        if (trig_ovf)
                        begin
                            state_next.running = 1'b0;
                        end
                        if (state_reg.envelope_reg[7:4] == 4'd0 && !state_reg.envelope_reg[3])
                        begin
                            state_next.running = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg.running)
        begin
            // duty generator, clocked every fourth tick
            if (state_reg.period_prescale == 2'd3)
            begin
                state_next.period_prescale = 2'd0;
                state_next.wave_high       = (state_reg.period_count >= threshold);
                state_next.period_count    = (count_inc >= PERIOD_WRAP) ?
                                             {1'b0, state_reg.period_value} : count_inc[11:0];
            end
            else
            begin
                state_next.period_prescale = state_reg.period_prescale + 2'd1;
            end

            // period sweep
            if (item.frame_step && state_reg.sweep_pace != 3'd0)
            begin
                if (state_reg.sweep_prescale == 2'd3)
                begin
                    state_next.sweep_prescale = 2'd0;
                    if (sweep_t >= {1'b0, state_reg.sweep_pace})
                    begin
                        state_next.sweep_pace_count = 3'd0;
                        if (tick_ovf)
                        begin
                            state_next.running = 1'b0;
                        end
                        state_next.period_value    = tick_period;
                        state_next.period_low_reg  = tick_period[7:0];
                        state_next.period_high_reg = {state_reg.period_high_reg[7:3],
                                                      tick_period[10:8]};
                        state_next.sweep_pace      = state_reg.sweep_reg[6:4];
                        state_next.sweep_down      = state_reg.sweep_reg[3];
                        state_next.sweep_shift     = state_reg.sweep_reg[2:0];
                    end
                    else
                    begin
                        state_next.sweep_pace_count = sweep_t[2:0];
                    end
                end
                else
                begin
                    state_next.sweep_prescale = state_reg.sweep_prescale + 2'd1;
                end
            end

            // length timer
            if (item.frame_step && state_reg.length_on)
            begin
                if (state_reg.length_prescale)
                begin
                    state_next.length_prescale = 1'b0;
                    if (length_t >= LEN_LIMIT)
                    begin
                        state_next.length_count = 7'd0;
                        state_next.running      = 1'b0;
                    end
                    else
                    begin
                        state_next.length_count = length_t[6:0];
                    end
                end
                else
                begin
                    state_next.length_prescale = 1'b1;
                end
            end

            // volume envelope, saturating
            if (item.frame_step && state_reg.env_pace != 3'd0)
            begin
                if (state_reg.env_prescale == 3'd7)
                begin
                    state_next.env_prescale = 3'd0;
                    if (env_t >= {1'b0, state_reg.env_pace})
                    begin
                        state_next.env_pace_count = 3'd0;
                        if (state_reg.env_up)
                        begin
                            if (state_reg.volume != 4'd15)
                            begin
                                state_next.volume = state_reg.volume + 4'd1;
                            end
                        end
                        else if (state_reg.volume != 4'd0)
                        begin
                            state_next.volume = state_reg.volume - 4'd1;
                        end
                    end
                    else
                    begin
                        state_next.env_pace_count = env_t[2:0];
                    end
                end
                else
                begin
                    state_next.env_prescale = state_reg.env_prescale + 3'd1;
                end
            end

            // silent downward envelope stops the channel
            if (state_next.volume == 4'd0 && !state_next.env_up)
            begin
                state_next.running = 1'b0;
            end
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
